[sv/lqa_pkg.sv]
// Package for the linear queue with aggregates: widths, codes and reset values.
// Used by the queue core and its checker; depends on nothing.
package lqa_pkg;

  localparam int unsigned LQA_DEPTH = 64;
  localparam int unsigned ITEM_W    = 32;
  localparam int unsigned VAL_W     = 38;
  localparam int unsigned CAP_W     = 7;
  localparam int unsigned STEP_W    = $clog2(VAL_W);

  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(64);

  typedef enum logic [2:0] {
    ACT_ENQ  = 3'd0,
    ACT_DEQ  = 3'd1,
    ACT_PEEK = 3'd2,
    ACT_LIST = 3'd3,
    ACT_SUM  = 3'd4,
    ACT_AVG  = 3'd5
  } action_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOAD,
    S_USE,
    S_PREP,
    S_DIV
  } state_e;

endpackage

[sv/lqa_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// Stands alone; no package needed.
module lqa_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

[sv/linear_queue_with_aggregates_core.sv]
// Linear (non-circular) array queue of signed 32-bit words with list, sum and
// average. Uses lqa_pkg and the lqa_ram slot memory.
//
// Command channel: a word (action_i, item_value_i) is taken at a rising edge
// with start high and busy low. Results come back on status_o,
// result_value_o, is_odd_o and last_o, each shown for exactly one cycle while
// strobe_o is high; the receiver cannot stall them. last_o marks the final
// result word of a command.
// Enqueue, and any command on an empty queue, answer in the cycle after
// acceptance and the next command may follow at once. Dequeue and peek
// pass through S_LOAD and S_USE (one slot memory read) before their answer.
// List walks the slot memory at one word per cycle: for n held words it
// returns n result words, busy through S_LOAD and the n words. Sum answers
// at the end of the walk; average adds a one-bit-per-cycle restoring
// divider, 38 steps after a setup step in S_PREP. Undefined actions are
// dropped with no result.
// Configuration: capacity is written over cfg_valid_i/cfg_ready_o/cfg_data_i,
// always ready; the user writes it only while idle; the block does not check.
// Reset: asynchronous, active low; the queue comes up empty, capacity 64.
// Slot memory contents are not cleared, so there is no clearing pass.
module linear_queue_with_aggregates_core
  import lqa_pkg::*;
#(
  parameter int unsigned DEPTH = LQA_DEPTH
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start,
  output logic                    busy,
  input  logic [2:0]              action_i,
  input  logic signed [ITEM_W-1:0] item_value_i,
  input  logic                    cfg_valid_i,
  output logic                    cfg_ready_o,
  input  logic [CAP_W-1:0]        cfg_data_i,
  output logic                    strobe_o,
  output logic [1:0]              status_o,
  output logic signed [VAL_W-1:0] result_value_o,
  output logic                    is_odd_o,
  output logic                    last_o
);

  localparam int unsigned IW    = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  state_e state_q, state_d;
  action_e op_q, op_d;

  logic [IW-1:0]    head_q, head_d, tail_q, tail_d, ptr_q, ptr_d;
  logic             active_q, active_d;
  logic [CAP_W-1:0] cap_q, cap_eff;
  logic             full;

  logic signed [VAL_W-1:0] sum_q, sum_d;
  logic [CNT_W-1:0]        cnt_q, cnt_d;
  logic [VAL_W-1:0]        quo_q, quo_d;
  logic [CNT_W-1:0]        rem_q, rem_d;
  logic [STEP_W-1:0]       step_q, step_d;
  logic                    neg_q, neg_d;

  logic                    strobe_q, strobe_d;
  status_e                 status_q, status_d;
  logic signed [VAL_W-1:0] value_q, value_d;
  logic                    odd_q, odd_d, last_q, last_d;

  logic                    we;
  logic [IW-1:0]           waddr, raddr;
  logic [ITEM_W-1:0]       rdata;
  logic signed [VAL_W-1:0] rd_sext;
  logic                    accept, last_elem;

  logic [CNT_W:0]   rem_sh;
  logic             div_ge;
  logic [VAL_W-1:0] quo_next;

  lqa_ram #(
    .WIDTH (ITEM_W),
    .DEPTH (DEPTH)
  ) u_slots (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (item_value_i),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign cfg_ready_o    = 1'b1;
  assign busy           = (state_q != S_IDLE);
  assign accept         = start && (state_q == S_IDLE);
  assign strobe_o       = strobe_q;
  assign status_o       = status_q;
  assign result_value_o = value_q;
  assign is_odd_o       = odd_q;
  assign last_o         = last_q;

  // Clamp capacity into 1..DEPTH.
  always_comb begin
    if (cap_q == '0) begin
      cap_eff = CAP_W'(1);
    end else if (cap_q > CAP_W'(DEPTH)) begin
      cap_eff = CAP_W'(DEPTH);
    end else begin
      cap_eff = cap_q;
    end
  end

  assign full      = (CAP_W'(tail_q) + CAP_W'(1)) >= cap_eff;
  assign rd_sext   = {{(VAL_W-ITEM_W){rdata[ITEM_W-1]}}, rdata};
  assign last_elem = (ptr_q == tail_q);
  // Stream the next slot while the current one is consumed.
  assign raddr     = (state_q == S_USE) ? IW'(ptr_q + IW'(1)) : ptr_q;

  // One restoring divide step.
  assign rem_sh   = {rem_q, quo_q[VAL_W-1]};
  assign div_ge   = rem_sh >= {1'b0, cnt_q};
  assign quo_next = {quo_q[VAL_W-2:0], div_ge};

  always_comb begin
    state_d  = state_q;
    op_d     = op_q;
    head_d   = head_q;
    tail_d   = tail_q;
    ptr_d    = ptr_q;
    active_d = active_q;
    sum_d    = sum_q;
    cnt_d    = cnt_q;
    quo_d    = quo_q;
    rem_d    = rem_q;
    step_d   = step_q;
    neg_d    = neg_q;
    strobe_d = 1'b0;
    status_d = ST_OK;
    value_d  = '0;
    odd_d    = 1'b0;
    last_d   = 1'b1;
    we       = 1'b0;
    waddr    = '0;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          op_d = action_e'(action_i);
          unique case (action_e'(action_i))
            ACT_ENQ: begin
              strobe_d = 1'b1;
              if (!active_q) begin
                head_d   = '0;
                tail_d   = '0;
                active_d = 1'b1;
                we       = 1'b1;
              end else if (full) begin
                status_d = ST_FULL;
              end else begin
                tail_d = IW'(tail_q + IW'(1));
                waddr  = tail_d;
                we     = 1'b1;
              end
            end
            ACT_DEQ, ACT_PEEK, ACT_LIST, ACT_SUM, ACT_AVG: begin
              if (!active_q) begin
                strobe_d = 1'b1;
                status_d = ST_EMPTY;
              end else begin
                ptr_d   = head_q;
                sum_d   = '0;
                cnt_d   = '0;
                state_d = S_LOAD;
              end
            end
            default: ;  // undefined action: drop
          endcase
        end
      end

      S_LOAD: state_d = S_USE;

      S_USE: begin
        unique case (op_q)
          ACT_DEQ: begin
            strobe_d = 1'b1;
            value_d  = rd_sext;
            state_d  = S_IDLE;
            if (head_q >= tail_q) begin
              head_d   = '0;
              tail_d   = '0;
              active_d = 1'b0;
            end else begin
              head_d = IW'(head_q + IW'(1));
            end
          end
          ACT_PEEK: begin
            strobe_d = 1'b1;
            value_d  = rd_sext;
            state_d  = S_IDLE;
          end
          ACT_LIST: begin
            strobe_d = 1'b1;
            value_d  = rd_sext;
            odd_d    = rdata[0];
            last_d   = last_elem;
            if (last_elem) begin
              state_d = S_IDLE;
            end else begin
              ptr_d = IW'(ptr_q + IW'(1));
            end
          end
          ACT_SUM, ACT_AVG: begin
            sum_d = sum_q + rd_sext;
            cnt_d = CNT_W'(cnt_q + CNT_W'(1));
            if (!last_elem) begin
              ptr_d = IW'(ptr_q + IW'(1));
            end else if (op_q == ACT_SUM) begin
              strobe_d = 1'b1;
              value_d  = sum_d;
              state_d  = S_IDLE;
            end else begin
              state_d = S_PREP;
            end
          end
          default: state_d = S_IDLE;
        endcase
      end

      S_PREP: begin
        // Divide the magnitude, restore the sign at the end.
        neg_d   = sum_q[VAL_W-1];
        quo_d   = sum_q[VAL_W-1] ? VAL_W'(-sum_q) : VAL_W'(sum_q);
        rem_d   = '0;
        step_d  = '0;
        state_d = S_DIV;
      end

      S_DIV: begin
        rem_d  = div_ge ? CNT_W'(rem_sh - {1'b0, cnt_q}) : CNT_W'(rem_sh);
        quo_d  = quo_next;
        step_d = STEP_W'(step_q + STEP_W'(1));
        if (step_q == STEP_W'(VAL_W - 1)) begin
          strobe_d = 1'b1;
          value_d  = neg_q ? VAL_W'(-quo_next) : VAL_W'(quo_next);
          state_d  = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      head_q   <= '0;
      tail_q   <= '0;
      active_q <= 1'b0;
      strobe_q <= 1'b0;
      cap_q    <= CAP_RESET;
    end else begin
      state_q  <= state_d;
      head_q   <= head_d;
      tail_q   <= tail_d;
      active_q <= active_d;
      strobe_q <= strobe_d;
      if (cfg_valid_i && cfg_ready_o) begin
        cap_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    op_q     <= op_d;
    ptr_q    <= ptr_d;
    sum_q    <= sum_d;
    cnt_q    <= cnt_d;
    quo_q    <= quo_d;
    rem_q    <= rem_d;
    step_q   <= step_d;
    neg_q    <= neg_d;
    status_q <= status_d;
    value_q  <= value_d;
    odd_q    <= odd_d;
    last_q   <= last_d;
  end

endmodule

[sv/lqa_checker.sv]
// Port-level checks for the queue core, bound onto every instance.
// Depends on lqa_pkg and linear_queue_with_aggregates_core.
module lqa_checker
  import lqa_pkg::*;
(
  input logic       clk_i,
  input logic       rst_ni,
  input logic       start,
  input logic       busy,
  input logic [2:0] action_i,
  input logic       strobe_o,
  input logic [1:0] status_o,
  input logic       last_o
);

  // A list stream has no gaps until its last word.
  a_list_gapless: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o && !last_o |=> strobe_o)
    else $error("result stream broke before its last word");

  // Enqueue answers in the next cycle with ok or full.
  a_enq_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy && action_i == ACT_ENQ |=>
      strobe_o && last_o && (status_o == ST_OK || status_o == ST_FULL))
    else $error("enqueue did not answer in one cycle");

  // Error answers end the command.
  a_err_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o && status_o != ST_OK |-> last_o)
    else $error("non-ok status without last");

  // More words to come means the block still works on the command.
  a_busy_mid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o && !last_o |-> busy)
    else $error("idle while a stream is open");

endmodule

bind linear_queue_with_aggregates_core lqa_checker u_lqa_checker (.*);

[tb/tb.sv]
// Self-checking bench for linear_queue_with_aggregates_core: directed and random
// commands, a queue predictor in a small scoreboard class, several capacities.
// Depends on lqa_pkg and the core.
module tb
  import lqa_pkg::*;
;

  localparam logic [2:0] ACT_RSVD_A   = 3'd6;
  localparam logic [2:0] ACT_RSVD_B   = 3'd7;
  localparam int         DRAIN_CYCLES = 120;
  localparam int         PHASES       = 8;
  localparam int         PHASE_WORDS  = 12;

  typedef struct {
    status_e                 status;
    logic signed [VAL_W-1:0] value;
    logic                    odd;
    logic                    last;
  } result_t;

  class queue_scoreboard;
    logic [ITEM_W-1:0] slots [LQA_DEPTH];
    logic [5:0]        head_idx;
    logic [5:0]        tail_idx;
    bit                held;
    logic [CAP_W-1:0]  capacity;
    result_t           pending [$];
    int                errors;

    function new();
      head_idx = '0;
      tail_idx = '0;
      held     = 1'b0;
      capacity = CAP_RESET;
      errors   = 0;
    endfunction

    function void push(status_e st, longint v, logic odd, logic lst);
      result_t r;
      r.status = st;
      r.value  = v[VAL_W-1:0];
      r.odd    = odd;
      r.last   = lst;
      pending.push_back(r);
    endfunction

    // Work out the result words of one accepted command word.
    function void note_command(logic [2:0] act, logic [ITEM_W-1:0] val);
      int     limit;
      longint total;
      int     count;
      if (capacity < 1) limit = 1;
      else if (capacity > LQA_DEPTH) limit = LQA_DEPTH;
      else limit = int'(capacity);
      if (act == ACT_ENQ) begin
        if (!held) begin
          head_idx = '0;
          tail_idx = '0;
          slots[0] = val;
          held     = 1'b1;
          push(ST_OK, 0, 1'b0, 1'b1);
        end else if (int'(tail_idx) + 1 >= limit) begin
          push(ST_FULL, 0, 1'b0, 1'b1);
        end else begin
          tail_idx++;
          slots[tail_idx] = val;
          push(ST_OK, 0, 1'b0, 1'b1);
        end
        return;
      end
      if (act > ACT_AVG) return;
      if (!held) begin
        push(ST_EMPTY, 0, 1'b0, 1'b1);
        return;
      end
      case (act)
        ACT_DEQ: begin
          push(ST_OK, signed'(slots[head_idx]), 1'b0, 1'b1);
          // Drain empty: both indices go back to zero.
          if (head_idx >= tail_idx) begin
            head_idx = '0;
            tail_idx = '0;
            held     = 1'b0;
          end else begin
            head_idx++;
          end
        end
        ACT_PEEK: push(ST_OK, signed'(slots[head_idx]), 1'b0, 1'b1);
        ACT_LIST: begin
          for (int i = int'(head_idx); i <= int'(tail_idx); i++)
            push(ST_OK, signed'(slots[i]), slots[i][0], i == int'(tail_idx));
        end
        default: begin
          total = 0;
          count = 0;
          for (int i = int'(head_idx); i <= int'(tail_idx); i++) begin
            total += signed'(slots[i]);
            count++;
          end
          push(ST_OK, (act == ACT_SUM) ? total : total / count, 1'b0, 1'b1);
        end
      endcase
    endfunction

    function void check_result(logic [1:0] st, logic signed [VAL_W-1:0] v,
                               logic odd, logic lst);
      result_t want;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result word status=%0d value=%0d odd=%0b last=%0b",
                 $time, st, v, odd, lst);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (st !== want.status) begin
        $display("%0t: status expected %0d actual %0d", $time, want.status, st);
        errors++;
      end
      if (v !== want.value) begin
        $display("%0t: result_value expected %0d actual %0d", $time, want.value, v);
        errors++;
      end
      if (odd !== want.odd) begin
        $display("%0t: is_odd expected %0b actual %0b", $time, want.odd, odd);
        errors++;
      end
      if (lst !== want.last) begin
        $display("%0t: last expected %0b actual %0b", $time, want.last, lst);
        errors++;
      end
    endfunction
  endclass

  logic                    clk_i = 1'b0;
  logic                    rst_ni;
  logic                    start;
  logic                    busy;
  logic [2:0]              action_i;
  logic signed [ITEM_W-1:0] item_value_i;
  logic                    cfg_valid_i;
  logic                    cfg_ready_o;
  logic [CAP_W-1:0]        cfg_data_i;
  logic                    strobe_o;
  logic [1:0]              status_o;
  logic signed [VAL_W-1:0] result_value_o;
  logic                    is_odd_o;
  logic                    last_o;

  queue_scoreboard sb = new();

  linear_queue_with_aggregates_core dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .action_i       (action_i),
    .item_value_i   (item_value_i),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_data_i     (cfg_data_i),
    .strobe_o       (strobe_o),
    .status_o       (status_o),
    .result_value_o (result_value_o),
    .is_odd_o       (is_odd_o),
    .last_o         (last_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni === 1'b1 && strobe_o === 1'b1)
      sb.check_result(status_o, result_value_o, is_odd_o, last_o);
  end

  // Hold start high until the word is taken; lower it only for a gap.
  task automatic send_command(logic [2:0] act, logic [ITEM_W-1:0] val, int gap);
    action_i     <= act;
    item_value_i <= val;
    start        <= 1'b1;
    do @(posedge clk_i); while (busy !== 1'b0);
    sb.note_command(act, val);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Wait for all results, then let any dropped word finish.
  task automatic settle();
    start <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    while (busy !== 1'b0) @(posedge clk_i);
  endtask

  task automatic write_capacity(logic [CAP_W-1:0] cap);
    cfg_data_i  <= cap;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (cfg_ready_o !== 1'b1);
    cfg_valid_i <= 1'b0;
    sb.capacity = cap;
  endtask

  function automatic int pick_gap();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: return 0;
      5, 6, 7:       return $urandom_range(1, 3);
      8:             return $urandom_range(4, 8);
      default:       return $urandom_range(15, 40);
    endcase
  endfunction

  function automatic logic [ITEM_W-1:0] pick_value();
    case ($urandom_range(0, 9))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2, 3, 4: return ITEM_W'($urandom_range(0, 40)) - 32'd20;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [2:0] pick_action(int enq_pct);
    int r;
    if ($urandom_range(0, 99) < enq_pct) return ACT_ENQ;
    r = $urandom_range(0, 99);
    if (r < 35) return ACT_DEQ;
    if (r < 50) return ACT_PEEK;
    if (r < 65) return ACT_LIST;
    if (r < 80) return ACT_SUM;
    if (r < 95) return ACT_AVG;
    return ($urandom_range(0, 1) != 0) ? ACT_RSVD_A : ACT_RSVD_B;
  endfunction

  initial begin
    logic [CAP_W-1:0] caps [PHASES];
    logic [2:0]       act;
    int               done;
    int               enq_pct;
    bit               steady;
    rst_ni       <= 1'b0;
    start        <= 1'b0;
    action_i     <= ACT_ENQ;
    item_value_i <= '0;
    cfg_valid_i  <= 1'b0;
    cfg_data_i   <= '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Commands on the empty queue, reserved actions included, then directed enqueues, aggregates and a drain.
    send_command(ACT_PEEK, '0, 0);
    send_command(ACT_DEQ, '0, 0);
    send_command(ACT_LIST, '0, 0);
    send_command(ACT_SUM, '0, 0);
    send_command(ACT_AVG, '0, 0);
    send_command(ACT_RSVD_A, 32'hFFFF_FFFF, 0);
    send_command(ACT_RSVD_B, '0, 0);
    send_command(ACT_ENQ, 32'h7FFF_FFFF, 0);
    send_command(ACT_ENQ, 32'h8000_0000, 0);
    send_command(ACT_ENQ, 32'hFFFF_FFFF, 0);
    send_command(ACT_ENQ, 32'h0000_0000, 0);
    send_command(ACT_ENQ, 32'h0000_0001, 0);
    send_command(ACT_LIST, '0, 0);
    send_command(ACT_SUM, '0, 0);
    send_command(ACT_AVG, '0, 0);
    send_command(ACT_PEEK, '0, 0);
    send_command(ACT_DEQ, '0, 0);
    send_command(ACT_AVG, '0, 0);
    send_command(ACT_ENQ, -32'sd7, 0);
    send_command(ACT_AVG, '0, 0);
    repeat (5) send_command(ACT_DEQ, '0, 0);
    settle();

    // Capacity one: second enqueue reports full until the queue drains.
    write_capacity(7'd1);
    send_command(ACT_ENQ, 32'd3, 0);
    send_command(ACT_ENQ, 32'd5, 0);
    send_command(ACT_DEQ, '0, 0);
    send_command(ACT_ENQ, 32'd9, 0);

    caps[0] = 7'd0;
    caps[1] = 7'd127;
    caps[2] = 7'd2;
    caps[3] = 7'd64;
    caps[4] = 7'd65;
    caps[5] = CAP_W'($urandom_range(3, 20));
    caps[6] = CAP_W'($urandom_range(0, 127));
    caps[7] = 7'd1;
    for (int p = 0; p < PHASES; p++) begin
      settle();
      write_capacity(caps[p]);
      case ($urandom_range(0, 2))
        0:       enq_pct = 40;
        1:       enq_pct = 55;
        default: enq_pct = 75;
      endcase
      steady = ($urandom_range(0, 3) == 0);
      done = 0;
      while (done < PHASE_WORDS) begin
        act = pick_action(enq_pct);
        send_command(act, pick_value(), steady ? 0 : pick_gap());
        if (act <= ACT_AVG) done++;
      end
    end
    settle();

    if (sb.pending.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, sb.pending.size());
      sb.errors++;
    end
    if (sb.errors == 0) begin
      $display("linear_queue_with_aggregates_core test passed");
    end else begin
      $display("linear_queue_with_aggregates_core test failed");
    end
    $finish;
  end

  initial begin
    #3000000;
    $display("linear_queue_with_aggregates_core test failed");
    $finish;
  end

endmodule
